FILE: rtl/sdlw_pkg.sv
`default_nettype none
package sdlw_pkg;

    // Frame geometry
    localparam int unsigned PAYLOAD_BYTES = 64;
    localparam int unsigned LEFT_W        = 7;
    localparam logic [LEFT_W-1:0] PAYLOAD_LOAD = LEFT_W'(PAYLOAD_BYTES);

    // Configuration port
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_VAL_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_LFSR_TAPS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LFSR_SEED     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MARKER  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MARKER = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [31:0] TAPS_RESET          = 32'h8020_0003;
    localparam logic [31:0] SEED_RESET          = 32'h0000_0001;
    localparam logic [7:0]  FIRST_MARKER_RESET  = 8'hAA;
    localparam logic [7:0]  SECOND_MARKER_RESET = 8'h55;

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_q_item;

    // Taps and seed load request towards the back
    typedef struct packed {
        logic        taps_we;
        logic        seed_we;
        logic [31:0] value;
    } t_lfsr_cfg;

endpackage
`default_nettype wire

FILE: rtl/sdlw_rx_if.sv
`default_nettype none
interface sdlw_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/sdlw_tx_if.sv
`default_nettype none
interface sdlw_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] white_byte;
    logic       frame_end;

    modport source (output valid, output white_byte, output frame_end, input ready);
    modport sink   (input valid, input white_byte, input frame_end, output ready);
endinterface
`default_nettype wire

FILE: rtl/sdlw_cfg_if.sv
`default_nettype none
interface sdlw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sdlw_pkg::CFG_IDX_W-1:0] index;
    logic [sdlw_pkg::CFG_VAL_W-1:0] value;

    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/sdlw_front.sv
`default_nettype none
module sdlw_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic [7:0]        i_first_marker,
    input  wire logic [7:0]        i_second_marker,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output sdlw_pkg::t_q_item      o_item
);

    localparam logic [1:0] PH_HUNT          = 2'd0;
    localparam logic [1:0] PH_GOT_FIRST     = 2'd1;
    localparam logic [1:0] PH_SECOND_CHANCE = 2'd2;
    localparam logic [1:0] PH_PAYLOAD       = 2'd3;

    logic [1:0]                  r_phase, n_phase;
    logic [sdlw_pkg::LEFT_W-1:0] r_left, n_left;
    logic                        accept;
    logic                        is_first, is_second, is_last;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign is_first  = (i_rx_byte == i_first_marker);
    assign is_second = (i_rx_byte == i_second_marker);
    assign is_last   = (r_left <= sdlw_pkg::LEFT_W'(1));

    assign o_item.data = i_rx_byte;
    assign o_item.last = is_last;
    assign o_push      = accept && (r_phase == PH_PAYLOAD);

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (is_first) n_phase = PH_GOT_FIRST;
                end
                PH_GOT_FIRST: begin
                    // second marker is tested first, so equal markers start the payload
                    if (is_second) begin
                        n_phase = PH_PAYLOAD;
                        n_left  = sdlw_pkg::PAYLOAD_LOAD;
                    end else if (is_first) begin
                        n_phase = PH_SECOND_CHANCE;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_SECOND_CHANCE: begin
                    if (is_second) begin
                        n_phase = PH_PAYLOAD;
                        n_left  = sdlw_pkg::PAYLOAD_LOAD;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_PAYLOAD: begin
                    if (is_last) begin
                        n_phase = PH_HUNT;
                        n_left  = '0;
                    end else begin
                        n_left  = r_left - sdlw_pkg::LEFT_W'(1);
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sdlw_queue.sv
`default_nettype none
module sdlw_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire sdlw_pkg::t_q_item i_item,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic                   o_full,
    output sdlw_pkg::t_q_item      o_item
);

    sdlw_pkg::t_q_item            r_mem [sdlw_pkg::Q_DEPTH];
    logic [sdlw_pkg::Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [sdlw_pkg::Q_CNT_W-1:0] r_count;
    logic                         do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == sdlw_pkg::Q_CNT_W'(sdlw_pkg::Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == sdlw_pkg::Q_PTR_W'(sdlw_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + sdlw_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == sdlw_pkg::Q_PTR_W'(sdlw_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + sdlw_pkg::Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + sdlw_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - sdlw_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sdlw_back.sv
`default_nettype none
module sdlw_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sdlw_pkg::t_lfsr_cfg i_cfg,
    input  wire logic               i_q_empty,
    input  wire sdlw_pkg::t_q_item  i_item,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [7:0]              o_white_byte,
    output logic                    o_frame_end
);

    logic [31:0] r_taps;
    logic [31:0] r_lfsr, n_lfsr;
    logic [7:0]  mask;
    logic        r_valid;
    logic [7:0]  r_white;
    logic        r_last;

    // Eight Galois steps; the first bit shifted out lands in the mask MSB
    always_comb begin
        n_lfsr = r_lfsr;
        mask   = '0;
        for (int i = 0; i < 8; i++) begin
            mask[7-i] = n_lfsr[0];
            n_lfsr    = n_lfsr[0] ? ({1'b0, n_lfsr[31:1]} ^ r_taps) : {1'b0, n_lfsr[31:1]};
        end
    end

    assign o_pop        = !i_q_empty && (!r_valid || i_ready);
    assign o_valid      = r_valid;
    assign o_white_byte = r_white;
    assign o_frame_end  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps  <= sdlw_pkg::TAPS_RESET;
            r_lfsr  <= sdlw_pkg::SEED_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg.taps_we) r_taps <= i_cfg.value;
            if (i_cfg.seed_we) begin
                r_lfsr <= i_cfg.value;
            end else if (o_pop) begin
                r_lfsr <= n_lfsr;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_white <= i_item.data ^ mask;
            r_last  <= i_item.last;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sync_deframer_lfsr_whitener.sv
`default_nettype none
// Byte-serial frame deframer with whitening. Each beat on i_rx carries one
// received byte; the block hunts for the first marker followed by the second
// marker (a repeated first marker gets one more chance), then passes the next
// PAYLOAD_BYTES bytes on o_tx, each XORed with eight bits of a right-shifting
// Galois LFSR, with frame_end set on the last byte. Header bytes produce no
// output beat. The LFSR advances only on payload bytes and runs on across
// frames; writing lfsr_seed (index 1) reloads it at once. Registers: 0 taps,
// 1 seed, 2 first marker, 3 second marker; other indexes are ignored, and the
// config port is always ready. Throughput is one byte per clock while the
// queue is not full: the marker FSM accepts a beat every cycle unless the
// two-entry queue that parts it from the whitening stage is full, and the
// eight LFSR steps are combinational ahead of the output register. An accepted
// payload byte passes through the queue and then the output register.
module sync_deframer_lfsr_whitener (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sdlw_rx_if.sink     i_rx,
    sdlw_tx_if.source   o_tx,
    sdlw_cfg_if.sink    i_cfg
);

    logic [7:0]          r_first_marker;
    logic [7:0]          r_second_marker;
    logic                cfg_we;
    sdlw_pkg::t_lfsr_cfg lfsr_cfg;

    logic                q_push, q_pop, q_empty, q_full;
    sdlw_pkg::t_q_item   q_in, q_out;

    // Config writes are registered; never stall the port
    assign i_cfg.ready    = 1'b1;
    assign cfg_we         = i_cfg.valid;
    assign lfsr_cfg.taps_we = cfg_we && (i_cfg.index == sdlw_pkg::CFG_LFSR_TAPS);
    assign lfsr_cfg.seed_we = cfg_we && (i_cfg.index == sdlw_pkg::CFG_LFSR_SEED);
    assign lfsr_cfg.value   = i_cfg.value;

    // Hold the marker registers here; the front compares against them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_marker  <= sdlw_pkg::FIRST_MARKER_RESET;
            r_second_marker <= sdlw_pkg::SECOND_MARKER_RESET;
        end else begin
            if (cfg_we && (i_cfg.index == sdlw_pkg::CFG_FIRST_MARKER)) begin
                r_first_marker <= i_cfg.value[7:0];
            end
            if (cfg_we && (i_cfg.index == sdlw_pkg::CFG_SECOND_MARKER)) begin
                r_second_marker <= i_cfg.value[7:0];
            end
        end
    end

    // Front: classify each beat, forward payload bytes with their end flag
    sdlw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_rx.valid),
        .o_ready         (i_rx.ready),
        .i_rx_byte       (i_rx.rx_byte),
        .i_first_marker  (r_first_marker),
        .i_second_marker (r_second_marker),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_item          (q_in)
    );

    // Short queue so a stalled sink does not stop header hunting at once
    sdlw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_item  (q_out)
    );

    // Back: advance the LFSR, whiten, register the output beat
    sdlw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (lfsr_cfg),
        .i_q_empty    (q_empty),
        .i_item       (q_out),
        .o_pop        (q_pop),
        .o_valid      (o_tx.valid),
        .i_ready      (o_tx.ready),
        .o_white_byte (o_tx.white_byte),
        .o_frame_end  (o_tx.frame_end)
    );

endmodule
`default_nettype wire

FILE: rtl/sdlw_checker.sv
`default_nettype none
module sdlw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_rx_valid,
    input wire logic       i_rx_ready,
    input wire logic       i_tx_valid,
    input wire logic       i_tx_ready,
    input wire logic [7:0] i_tx_white_byte,
    input wire logic       i_tx_frame_end,
    input wire logic       i_cfg_ready
);

    // A stalled output beat stays offered
    a_tx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tx_valid && !i_tx_ready) |=> i_tx_valid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload
    a_tx_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tx_valid && !i_tx_ready) |=> ($stable(i_tx_white_byte) && $stable(i_tx_frame_end)))
        else $error("output payload changed while stalled");

    // With no output pending the queue cannot be full, so input must be ready
    a_rx_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_tx_valid |-> i_rx_ready)
        else $error("input stalled with output drained");

    // The configuration port never back-pressures
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");

    // An input beat never turns into an output beat in the same or next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(i_tx_valid) && !$past(i_tx_valid)) |-> $past(i_rx_valid && i_rx_ready, 2))
        else $error("output beat without an input beat two cycles before");

endmodule

bind sync_deframer_lfsr_whitener sdlw_checker u_sdlw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rx_valid      (i_rx.valid),
    .i_rx_ready      (i_rx.ready),
    .i_tx_valid      (o_tx.valid),
    .i_tx_ready      (o_tx.ready),
    .i_tx_white_byte (o_tx.white_byte),
    .i_tx_frame_end  (o_tx.frame_end),
    .i_cfg_ready     (i_cfg.ready)
);
`default_nettype wire
